### design/fmtr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FM timer port package
// Shared widths, register addresses, item kinds and port groups.
// ----------------------------------------------------------------------------
package fmtr_pkg;

  // Payload field widths.
  localparam int KIND_W    = 2;
  localparam int PORT_W    = 8;
  localparam int DATA_W    = 8;
  localparam int CYCLES_W  = 10;
  localparam int STATUS_W  = 2;
  localparam int IRQEN_W   = 2;
  localparam int BANK_W    = 3;
  localparam int BANKOFS_W = 17;
  localparam int KEYON_W   = 16;

  // FM register file.
  localparam int FM_REGS   = 256;
  localparam int FM_ADDR_W = 8;

  // Parameter defaults.
  localparam int DEF_MAX_TICK_CYCLES = 512;
  localparam int DEF_TIMER_A_SCALE   = 128;
  localparam int DEF_TIMER_B_SCALE   = 2048;

  // Timer period bases.
  localparam int TA_BASE = 1024;
  localparam int TB_BASE = 256;

  // FM register addresses with side effects.
  localparam logic [FM_ADDR_W-1:0] REG_KEYON      = 8'h08;
  localparam logic [FM_ADDR_W-1:0] REG_TA_HI      = 8'h10;
  localparam logic [FM_ADDR_W-1:0] REG_TA_LO      = 8'h11;
  localparam logic [FM_ADDR_W-1:0] REG_TB         = 8'h12;
  localparam logic [FM_ADDR_W-1:0] REG_TIMER_CTRL = 8'h14;

  // Key-on channel mask.
  localparam logic [DATA_W-1:0] KEYON_MASK = 8'h78;

  // Sample bank size in bytes.
  localparam logic [BANKOFS_W-1:0] BANK_STRIDE = 17'h04000;

  // Port read values.
  localparam logic [DATA_W-1:0] RD_OPEN_BUS = 8'hFF;
  localparam logic [DATA_W-1:0] RD_ZERO     = 8'h00;

  // Port groups selected by port bits 7:6.
  localparam logic [1:0] GRP_FM   = 2'd0;
  localparam logic [1:0] GRP_BANK = 2'd1;
  localparam logic [1:0] GRP_NONE = 2'd2;
  localparam logic [1:0] GRP_HOST = 2'd3;

  typedef enum logic [KIND_W-1:0] {
    KIND_PORT_WR = 2'd0,
    KIND_PORT_RD = 2'd1,
    KIND_TICK    = 2'd2,
    KIND_HOST_WR = 2'd3
  } kind_t;

endpackage

### design/fmtr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FM timer port channels
// Valid/ready channel interfaces for input items and result beats.
// ----------------------------------------------------------------------------
interface fmtr_in_if;
  logic                          valid;
  logic                          ready;
  logic [fmtr_pkg::KIND_W-1:0]   kind;
  logic [fmtr_pkg::PORT_W-1:0]   port;
  logic [fmtr_pkg::DATA_W-1:0]   data;
  logic [fmtr_pkg::CYCLES_W-1:0] cycles;

  modport source (output valid, kind, port, data, cycles, input ready);
  modport sink   (input valid, kind, port, data, cycles, output ready);
endinterface

interface fmtr_out_if;
  logic                           valid;
  logic                           ready;
  logic [fmtr_pkg::DATA_W-1:0]    read_data;
  logic [fmtr_pkg::STATUS_W-1:0]  status_flags;
  logic                           command_pending;
  logic [fmtr_pkg::IRQEN_W-1:0]   timer_irq_enables;
  logic [fmtr_pkg::BANKOFS_W-1:0] bank_offset;
  logic [fmtr_pkg::KEYON_W-1:0]   keyon_count;

  modport source (output valid, read_data, status_flags, command_pending,
                  timer_irq_enables, bank_offset, keyon_count, input ready);
  modport sink   (input valid, read_data, status_flags, command_pending,
                  timer_irq_enables, bank_offset, keyon_count, output ready);
endinterface

### design/fm_chip_timer_register_port_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FM chip timer and register port
// Port decoder, FM register file, timers A/B, status, command latch, bank.
// ----------------------------------------------------------------------------
// Each input beat is one item (port write, port read, time tick or host
// command write) and yields exactly one result beat that shows the block's
// state after the item. The FM register file lives in a 256x8 RAM with a
// registered read; after reset a clearing pass writes zero to all 256
// entries, one per cycle, and no item is accepted until the pass ends.
// Items are processed one at a time. Most items pass through the execute
// and done states. A write to the timer control register that loads a
// timer also passes RD1, RD2, RD3, PER and LOAD: the period registers 0x10,
// 0x11 and 0x12 are fetched one after another through the single RAM read
// port and the period is then formed. A tick that underflows a timer passes
// the same read and period states, then the wrap loop, which subtracts one
// period per cycle until each overshoot is below a period. A tick that wraps
// neither timer goes from execute to done. A new item is taken while a result
// still waits on the output; a following item then stalls only in DONE.
// ----------------------------------------------------------------------------
module fm_chip_timer_register_port_top #(
  parameter int MAX_TICK_CYCLES = fmtr_pkg::DEF_MAX_TICK_CYCLES,
  parameter int TIMER_A_SCALE   = fmtr_pkg::DEF_TIMER_A_SCALE,
  parameter int TIMER_B_SCALE   = fmtr_pkg::DEF_TIMER_B_SCALE
) (
  input  logic       clk,
  input  logic       rst_n,
  fmtr_in_if.sink    in_bus,
  fmtr_out_if.source out_bus
);

  import fmtr_pkg::*;

  // Width of a clamped tick length.
  localparam int CW    = $clog2(MAX_TICK_CYCLES + 1);
  localparam int CMPW  = (CW > CYCLES_W) ? CW : CYCLES_W;
  // Timer counts hold values up to one full period.
  localparam int PA_W  = $clog2(TA_BASE * TIMER_A_SCALE + 1);
  localparam int PB_W  = $clog2(TB_BASE * TIMER_B_SCALE + 1);
  localparam int ACMPW = (PA_W > CW) ? PA_W : CW;
  localparam int BCMPW = (PB_W > CW) ? PB_W : CW;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_RD1,
    S_RD2,
    S_RD3,
    S_PER,
    S_LOAD,
    S_LOOP,
    S_DONE
  } state_t;

  // Sequencer and clearing pass.
  state_t               state_r, state_nxt;
  logic [FM_ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  // Item being processed.
  kind_t             kind_r, kind_nxt;
  logic [PORT_W-1:0] port_r, port_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic [CW-1:0]     cyc_r, cyc_nxt;

  // Architectural state outside the register file.
  logic [FM_ADDR_W-1:0] fm_addr_r, fm_addr_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic [IRQEN_W-1:0]   irq_en_r, irq_en_nxt;
  logic [1:0]           running_r, running_nxt;
  logic [PA_W-1:0]      cnt_a_r, cnt_a_nxt;
  logic [PB_W-1:0]      cnt_b_r, cnt_b_nxt;
  logic [DATA_W-1:0]    latch_r, latch_nxt;
  logic                 cmd_flag_r, cmd_flag_nxt;
  logic [BANK_W-1:0]    bank_r, bank_nxt;
  logic [KEYON_W-1:0]   keyons_r, keyons_nxt;

  // Working registers.
  logic [DATA_W-1:0] rd_r, rd_nxt;
  logic [DATA_W-1:0] r10_r, r10_nxt;
  logic [1:0]        r11_r, r11_nxt;
  logic [DATA_W-1:0] r12_r, r12_nxt;
  logic [PA_W-1:0]   per_a_r, per_a_nxt;
  logic [PB_W-1:0]   per_b_r, per_b_nxt;
  logic [CW-1:0]     d_a_r, d_a_nxt;
  logic [CW-1:0]     d_b_r, d_b_nxt;
  logic [1:0]        pend_r, pend_nxt;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]    out_rd_r, out_rd_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic                 out_cmd_r, out_cmd_nxt;
  logic [IRQEN_W-1:0]   out_irq_r, out_irq_nxt;
  logic [BANKOFS_W-1:0] out_bank_r, out_bank_nxt;
  logic [KEYON_W-1:0]   out_keyon_r, out_keyon_nxt;

  // RAM port.
  logic                 ram_we;
  logic [FM_ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0]    ram_wdata;
  logic [FM_ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0]    ram_rdata;

  logic [1:0]  group;
  logic        in_fire;
  logic [9:0]  ta_load;
  logic [CW-1:0] cyc_clamp;

  fmtr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (FM_REGS)
  ) u_regs (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_bus.ready = (state_r == S_IDLE);
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign group        = port_r[PORT_W-1 -: 2];
  assign ta_load      = {r10_r, r11_r};

  // Long ticks saturate at the tick limit.
  assign cyc_clamp = (CMPW'(in_bus.cycles) > CMPW'(MAX_TICK_CYCLES))
                     ? CW'(MAX_TICK_CYCLES) : CW'(in_bus.cycles);

  assign out_bus.valid             = out_valid_r;
  assign out_bus.read_data         = out_rd_r;
  assign out_bus.status_flags      = out_status_r;
  assign out_bus.command_pending   = out_cmd_r;
  assign out_bus.timer_irq_enables = out_irq_r;
  assign out_bus.bank_offset       = out_bank_r;
  assign out_bus.keyon_count       = out_keyon_r;

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    kind_nxt       = kind_r;
    port_nxt       = port_r;
    data_nxt       = data_r;
    cyc_nxt        = cyc_r;
    fm_addr_nxt    = fm_addr_r;
    status_nxt     = status_r;
    irq_en_nxt     = irq_en_r;
    running_nxt    = running_r;
    cnt_a_nxt      = cnt_a_r;
    cnt_b_nxt      = cnt_b_r;
    latch_nxt      = latch_r;
    cmd_flag_nxt   = cmd_flag_r;
    bank_nxt       = bank_r;
    keyons_nxt     = keyons_r;
    rd_nxt         = rd_r;
    r10_nxt        = r10_r;
    r11_nxt        = r11_r;
    r12_nxt        = r12_r;
    per_a_nxt      = per_a_r;
    per_b_nxt      = per_b_r;
    d_a_nxt        = d_a_r;
    d_b_nxt        = d_b_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_bus.ready;
    out_rd_nxt     = out_rd_r;
    out_status_nxt = out_status_r;
    out_cmd_nxt    = out_cmd_r;
    out_irq_nxt    = out_irq_r;
    out_bank_nxt   = out_bank_r;
    out_keyon_nxt  = out_keyon_r;
    ram_we         = 1'b0;
    ram_waddr      = fm_addr_r;
    ram_wdata      = data_r;
    // The period fetch starts in the execute cycle; the read is harmless
    // for items that do not use it.
    ram_raddr      = REG_TA_HI;

    unique case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == FM_ADDR_W'(FM_REGS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          kind_nxt  = kind_t'(in_bus.kind);
          port_nxt  = in_bus.port;
          data_nxt  = in_bus.data;
          cyc_nxt   = cyc_clamp;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        rd_nxt    = RD_ZERO;
        pend_nxt  = 2'b00;
        state_nxt = S_DONE;
        unique case (kind_r)
          KIND_PORT_WR: begin
            if (group == GRP_FM) begin
              if (!port_r[0]) begin
                fm_addr_nxt = data_r;
              end else begin
                ram_we = 1'b1;
                if (fm_addr_r == REG_KEYON && (data_r & KEYON_MASK) != '0) begin
                  keyons_nxt = keyons_r + 1'b1;
                end
                if (fm_addr_r == REG_TIMER_CTRL) begin
                  irq_en_nxt  = data_r[3:2];
                  running_nxt = data_r[1:0];
                  status_nxt  = status_r & ~data_r[5:4];
                  pend_nxt    = data_r[1:0];
                  if (data_r[1:0] != 2'b00) begin
                    state_nxt = S_RD1;
                  end
                end
              end
            end else if (group == GRP_BANK) begin
              bank_nxt = data_r[BANK_W-1:0];
            end
          end

          KIND_PORT_RD: begin
            unique case (group)
              GRP_FM:   rd_nxt = DATA_W'(status_r);
              GRP_BANK: rd_nxt = RD_OPEN_BUS;
              GRP_NONE: rd_nxt = RD_ZERO;
              GRP_HOST: begin
                rd_nxt       = latch_r;
                cmd_flag_nxt = 1'b0;
              end
              default:  rd_nxt = RD_ZERO;
            endcase
          end

          KIND_TICK: begin
            // A timer that reaches zero or below flags at once; the
            // remaining overshoot is resolved in the wrap loop.
            if (running_r[0]) begin
              if (ACMPW'(cnt_a_r) > ACMPW'(cyc_r)) begin
                cnt_a_nxt = PA_W'(ACMPW'(cnt_a_r) - ACMPW'(cyc_r));
              end else begin
                d_a_nxt       = CW'(ACMPW'(cyc_r) - ACMPW'(cnt_a_r));
                pend_nxt[0]   = 1'b1;
                status_nxt[0] = 1'b1;
              end
            end
            if (running_r[1]) begin
              if (BCMPW'(cnt_b_r) > BCMPW'(cyc_r)) begin
                cnt_b_nxt = PB_W'(BCMPW'(cnt_b_r) - BCMPW'(cyc_r));
              end else begin
                d_b_nxt       = CW'(BCMPW'(cyc_r) - BCMPW'(cnt_b_r));
                pend_nxt[1]   = 1'b1;
                status_nxt[1] = 1'b1;
              end
            end
            if ((running_r[0] && ACMPW'(cnt_a_r) <= ACMPW'(cyc_r)) ||
                (running_r[1] && BCMPW'(cnt_b_r) <= BCMPW'(cyc_r))) begin
              state_nxt = S_RD1;
            end
          end

          KIND_HOST_WR: begin
            latch_nxt    = data_r;
            cmd_flag_nxt = 1'b1;
          end

          default: ;
        endcase
      end

      S_RD1: begin
        r10_nxt   = ram_rdata;
        ram_raddr = REG_TA_LO;
        state_nxt = S_RD2;
      end

      S_RD2: begin
        r11_nxt   = ram_rdata[1:0];
        ram_raddr = REG_TB;
        state_nxt = S_RD3;
      end

      S_RD3: begin
        r12_nxt   = ram_rdata;
        state_nxt = S_PER;
      end

      S_PER: begin
        per_a_nxt = PA_W'(PA_W'(11'(TA_BASE) - {1'b0, ta_load}) * PA_W'(TIMER_A_SCALE));
        per_b_nxt = PB_W'(PB_W'(9'(TB_BASE) - {1'b0, r12_r}) * PB_W'(TIMER_B_SCALE));
        state_nxt = (kind_r == KIND_TICK) ? S_LOOP : S_LOAD;
      end

      S_LOAD: begin
        if (pend_r[0]) begin
          cnt_a_nxt = per_a_r;
        end
        if (pend_r[1]) begin
          cnt_b_nxt = per_b_r;
        end
        pend_nxt  = 2'b00;
        state_nxt = S_DONE;
      end

      S_LOOP: begin
        // One period per cycle until the overshoot is below a period.
        if (pend_r[0]) begin
          if (ACMPW'(d_a_r) >= ACMPW'(per_a_r)) begin
            d_a_nxt = CW'(ACMPW'(d_a_r) - ACMPW'(per_a_r));
          end else begin
            cnt_a_nxt   = PA_W'(ACMPW'(per_a_r) - ACMPW'(d_a_r));
            pend_nxt[0] = 1'b0;
          end
        end
        if (pend_r[1]) begin
          if (BCMPW'(d_b_r) >= BCMPW'(per_b_r)) begin
            d_b_nxt = CW'(BCMPW'(d_b_r) - BCMPW'(per_b_r));
          end else begin
            cnt_b_nxt   = PB_W'(BCMPW'(per_b_r) - BCMPW'(d_b_r));
            pend_nxt[1] = 1'b0;
          end
        end
        if (pend_nxt == 2'b00) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_bus.ready) begin
          out_valid_nxt  = 1'b1;
          out_rd_nxt     = rd_r;
          out_status_nxt = status_r;
          out_cmd_nxt    = cmd_flag_r;
          out_irq_nxt    = irq_en_r;
          out_bank_nxt   = BANKOFS_W'(bank_r) * BANK_STRIDE;
          out_keyon_nxt  = keyons_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      fm_addr_r   <= '0;
      status_r    <= '0;
      irq_en_r    <= '0;
      running_r   <= '0;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      latch_r     <= '0;
      cmd_flag_r  <= 1'b0;
      bank_r      <= '0;
      keyons_r    <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      fm_addr_r   <= fm_addr_nxt;
      status_r    <= status_nxt;
      irq_en_r    <= irq_en_nxt;
      running_r   <= running_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      latch_r     <= latch_nxt;
      cmd_flag_r  <= cmd_flag_nxt;
      bank_r      <= bank_nxt;
      keyons_r    <= keyons_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r       <= kind_nxt;
    port_r       <= port_nxt;
    data_r       <= data_nxt;
    cyc_r        <= cyc_nxt;
    rd_r         <= rd_nxt;
    r10_r        <= r10_nxt;
    r11_r        <= r11_nxt;
    r12_r        <= r12_nxt;
    per_a_r      <= per_a_nxt;
    per_b_r      <= per_b_nxt;
    d_a_r        <= d_a_nxt;
    d_b_r        <= d_b_nxt;
    out_rd_r     <= out_rd_nxt;
    out_status_r <= out_status_nxt;
    out_cmd_r    <= out_cmd_nxt;
    out_irq_r    <= out_irq_nxt;
    out_bank_r   <= out_bank_nxt;
    out_keyon_r  <= out_keyon_nxt;
  end

  // Status flags are only ever set by a tick.
  a_flag_set_by_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r & ~$past(status_r)) != '0 |-> $past(kind_r) == KIND_TICK)
    else $error("status flag set outside a tick");

  // A running timer at rest never holds a zero count.
  a_cnt_a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE && running_r[0] |-> cnt_a_r != '0)
    else $error("timer A running with zero count");

  a_cnt_b_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE && running_r[1] |-> cnt_b_r != '0)
    else $error("timer B running with zero count");

  // The key-on counter moves only on an FM port write.
  a_keyon_source: assert property (@(posedge clk) disable iff (!rst_n)
    keyons_r != $past(keyons_r) |->
      $past(state_r) == S_EXEC && $past(kind_r) == KIND_PORT_WR)
    else $error("key-on count changed outside a port write");

  // A new result beat is produced only from the final sequencer step.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result beat without a finished item");

endmodule

### design/fmtr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FM timer port RAM
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fmtr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### verif/fmtr_port_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FM timer port result checker
// Watches the item and result channels, keeps its own copy of the FM port
// state, predicts one result per accepted item and compares field by field.
// ----------------------------------------------------------------------------
module fmtr_port_checker #(
  parameter int MAX_TICK_CYCLES = fmtr_pkg::DEF_MAX_TICK_CYCLES,
  parameter int TIMER_A_SCALE   = fmtr_pkg::DEF_TIMER_A_SCALE,
  parameter int TIMER_B_SCALE   = fmtr_pkg::DEF_TIMER_B_SCALE
) (
  input  logic clk,
  input  logic rst_n,
  fmtr_in_if   in_mon,
  fmtr_out_if  out_mon,
  output int   mismatches,
  output int   awaiting
);
  import fmtr_pkg::*;

  localparam logic [STATUS_W-1:0] FLAG_A = 2'b01;
  localparam logic [STATUS_W-1:0] FLAG_B = 2'b10;

  // Layout of the byte written to the timer control register.
  typedef struct packed {
    logic [1:0]         unused;
    logic               clear_b;
    logic               clear_a;
    logic [IRQEN_W-1:0] irq_en;
    logic               load_b;
    logic               load_a;
  } timer_ctrl_t;

  typedef struct packed {
    logic [DATA_W-1:0]    read_data;
    logic [STATUS_W-1:0]  status_flags;
    logic                 command_pending;
    logic [IRQEN_W-1:0]   timer_irq_enables;
    logic [BANKOFS_W-1:0] bank_offset;
    logic [KEYON_W-1:0]   keyon_count;
  } port_result_t;

  logic [DATA_W-1:0]    fm_regs [FM_REGS];
  logic [FM_ADDR_W-1:0] fm_addr;
  logic [STATUS_W-1:0]  flags;
  logic [IRQEN_W-1:0]   irq_en;
  logic [1:0]           running;
  longint               count_a;
  longint               count_b;
  logic [DATA_W-1:0]    host_cmd;
  logic                 host_cmd_full;
  logic [BANK_W-1:0]    bank;
  logic [KEYON_W-1:0]   keyons_seen;
  port_result_t         expected_results [$];

  initial mismatches = 0;

  function automatic longint period_a();
    longint t;
    t = fm_regs[REG_TA_HI];
    t = t * 4 + fm_regs[REG_TA_LO][1:0];
    return (TA_BASE - t) * TIMER_A_SCALE;
  endfunction

  function automatic longint period_b();
    longint t;
    t = fm_regs[REG_TB];
    return (TB_BASE - t) * TIMER_B_SCALE;
  endfunction

  // Several wraps in one tick raise the flag once; the count keeps the rest.
  function automatic longint count_down(longint count, longint elapsed,
                                        longint period, logic [STATUS_W-1:0] flag);
    longint left;
    left = count - elapsed;
    while (left <= 0) begin
      flags = flags | flag;
      left  = left + period;
    end
    return left;
  endfunction

  function automatic port_result_t apply_port_item(kind_t k, logic [PORT_W-1:0] p,
                                                   logic [DATA_W-1:0] d,
                                                   logic [CYCLES_W-1:0] c);
    port_result_t r;
    timer_ctrl_t  ctl;
    longint       elapsed;
    logic [1:0]   grp;
    grp         = p[7:6];
    r.read_data = RD_ZERO;
    case (k)
      KIND_PORT_WR: begin
        if (grp == GRP_FM && !p[0]) begin
          fm_addr = d;
        end else if (grp == GRP_FM) begin
          fm_regs[fm_addr] = d;
          if (fm_addr == REG_KEYON && (d & KEYON_MASK) != '0) keyons_seen = keyons_seen + 1'b1;
          if (fm_addr == REG_TIMER_CTRL) begin
            ctl    = d;
            irq_en = ctl.irq_en;
            if (ctl.load_a) begin
              count_a = period_a();
              running = running | FLAG_A;
            end else begin
              running = running & ~FLAG_A;
            end
            if (ctl.load_b) begin
              count_b = period_b();
              running = running | FLAG_B;
            end else begin
              running = running & ~FLAG_B;
            end
            if (ctl.clear_a) flags = flags & ~FLAG_A;
            if (ctl.clear_b) flags = flags & ~FLAG_B;
          end
        end else if (grp == GRP_BANK) begin
          bank = d[BANK_W-1:0];
        end
      end
      KIND_PORT_RD: begin
        case (grp)
          GRP_FM:   r.read_data = {{(DATA_W-STATUS_W){1'b0}}, flags};
          GRP_HOST: begin
            host_cmd_full = 1'b0;
            r.read_data   = host_cmd;
          end
          GRP_NONE: r.read_data = RD_ZERO;
          default:  r.read_data = RD_OPEN_BUS;
        endcase
      end
      KIND_TICK: begin
        elapsed = c;
        if (elapsed > MAX_TICK_CYCLES) elapsed = MAX_TICK_CYCLES;
        if (running[0]) count_a = count_down(count_a, elapsed, period_a(), FLAG_A);
        if (running[1]) count_b = count_down(count_b, elapsed, period_b(), FLAG_B);
      end
      default: begin
        host_cmd      = d;
        host_cmd_full = 1'b1;
      end
    endcase
    r.status_flags      = flags;
    r.command_pending   = host_cmd_full;
    r.timer_irq_enables = irq_en;
    r.bank_offset       = BANK_STRIDE * bank;
    r.keyon_count       = keyons_seen;
    return r;
  endfunction

  function automatic int field_differs(string field, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    port_result_t want;
    if (!rst_n) begin
      foreach (fm_regs[i]) fm_regs[i] = '0;
      fm_addr       = '0;
      flags         = '0;
      irq_en        = '0;
      running       = '0;
      count_a       = 0;
      count_b       = 0;
      host_cmd      = '0;
      host_cmd_full = 1'b0;
      bank          = '0;
      keyons_seen   = '0;
      expected_results.delete();
    end else begin
      // A result can never belong to an item taken at the same edge.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat arrived with no item outstanding");
          mismatches = mismatches + 1;
        end else begin
          want = expected_results.pop_front();
          mismatches = mismatches
            + field_differs("read_data", want.read_data, out_mon.read_data)
            + field_differs("status_flags", want.status_flags, out_mon.status_flags)
            + field_differs("command_pending", want.command_pending,
                            out_mon.command_pending)
            + field_differs("timer_irq_enables", want.timer_irq_enables,
                            out_mon.timer_irq_enables)
            + field_differs("bank_offset", want.bank_offset, out_mon.bank_offset)
            + field_differs("keyon_count", want.keyon_count, out_mon.keyon_count);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_results.push_back(apply_port_item(kind_t'(in_mon.kind), in_mon.port,
                                                   in_mon.data, in_mon.cycles));
      end
    end
    awaiting <= expected_results.size();
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FM chip timer and register port testbench
// Drives port writes, port reads, ticks and host command writes with random
// gaps and output stalls; a checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb;
  import fmtr_pkg::*;

  // Bits of the timer control byte written to register 0x14.
  localparam logic [DATA_W-1:0] TCTL_LOAD_A = 8'h01;
  localparam logic [DATA_W-1:0] TCTL_LOAD_B = 8'h02;
  localparam logic [DATA_W-1:0] TCTL_EN_A   = 8'h04;
  localparam logic [DATA_W-1:0] TCTL_EN_B   = 8'h08;
  localparam logic [DATA_W-1:0] TCTL_CLR_A  = 8'h10;
  localparam logic [DATA_W-1:0] TCTL_CLR_B  = 8'h20;

  localparam int ITEM_TARGET  = 550;
  localparam int DRAIN_CYCLES = 40;
  // The slowest run is roughly the clearing pass plus, per item, the widest
  // input gap, the longest item work and the longest output stall, summed
  // over the items sent; the limit allows many times more.
  localparam int CYCLE_LIMIT  = 300000;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   awaiting;
  int   items_sent;
  int   cycle_count = 0;
  bit   no_idle;

  fmtr_in_if  in_bus ();
  fmtr_out_if out_bus ();

  fm_chip_timer_register_port_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  fmtr_port_checker port_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Both sides draw a wait per beat. During quiet phases neither side idles,
  // so back-to-back beats also get exercised.
  function automatic int idle_cycles();
    if (no_idle) return 0;
    return $urandom_range(0, 8);
  endfunction

  // Presents one item and returns at the edge where it is accepted. When the
  // next item follows with no gap, valid simply stays high.
  task automatic send_item(kind_t k, logic [PORT_W-1:0] p, logic [DATA_W-1:0] d,
                           logic [CYCLES_W-1:0] c);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid  <= 1'b1;
    in_bus.kind   <= k;
    in_bus.port   <= p;
    in_bus.data   <= d;
    in_bus.cycles <= c;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    items_sent = items_sent + 1;
    if (items_sent % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
  endtask

  // An FM register write is an address beat followed by a data beat. The
  // unused port bits 5:1 are randomized since the block must ignore them.
  task automatic write_fm_reg(logic [FM_ADDR_W-1:0] addr, logic [DATA_W-1:0] val);
    send_item(KIND_PORT_WR, {GRP_FM, 5'($urandom), 1'b0}, addr, 10'($urandom));
    send_item(KIND_PORT_WR, {GRP_FM, 5'($urandom), 1'b1}, val, 10'($urandom));
  endtask

  task automatic send_read(logic [1:0] grp);
    send_item(KIND_PORT_RD, {grp, 6'($urandom)}, 8'($urandom), 10'($urandom));
  endtask

  task automatic send_tick(logic [CYCLES_W-1:0] c);
    send_item(KIND_TICK, 8'($urandom), 8'($urandom), c);
  endtask

  // Mostly legal traffic that keeps the timers running and overflowing: the
  // period registers lean toward short periods so that flags actually get
  // set within a few ticks. A tenth of the scenes are pure noise.
  task automatic send_random_scene();
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        case ($urandom_range(0, 5))
          0: write_fm_reg(REG_KEYON, 8'($urandom));
          1: write_fm_reg(REG_TA_HI, ($urandom_range(0, 4) != 0) ?
                          8'($urandom_range(8'hE0, 8'hFF)) : 8'($urandom));
          2: write_fm_reg(REG_TA_LO, 8'($urandom));
          3: write_fm_reg(REG_TB, ($urandom_range(0, 4) != 0) ?
                          8'($urandom_range(8'hF8, 8'hFF)) : 8'($urandom));
          4: write_fm_reg(REG_TIMER_CTRL, 8'($urandom));
          default: write_fm_reg(8'($urandom), 8'($urandom));
        endcase
      end
      3, 4, 5: begin
        // An occasional tick is longer than the block clamps to.
        if ($urandom_range(0, 9) == 0) send_tick(10'($urandom_range(513, 1023)));
        else send_tick(10'($urandom_range(0, 512)));
      end
      6: send_read(2'($urandom));
      7: send_item(KIND_HOST_WR, 8'($urandom), 8'($urandom), 10'($urandom));
      8: send_item(KIND_PORT_WR, {2'($urandom_range(1, 3)), 6'($urandom)},
                   8'($urandom), 10'($urandom));
      default: send_item(kind_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                         10'($urandom));
    endcase
  endtask

  // Result side: a fresh stall is drawn for every result beat.
  initial begin
    int stall;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
    end
  end

  initial begin
    items_sent = 0;
    no_idle    = 1'b0;
    rst_n         <= 1'b0;
    in_bus.valid  <= 1'b0;
    in_bus.kind   <= KIND_PORT_WR;
    in_bus.port   <= '0;
    in_bus.data   <= '0;
    in_bus.cycles <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // The register-file clearing pass holds ready low; send_item simply
    // waits it out through the handshake.

    // Reads of every group from the reset state: status, open bus, zero
    // and the (still empty) command latch.
    send_read(GRP_FM);
    send_read(GRP_BANK);
    send_read(GRP_NONE);
    send_read(GRP_HOST);

    // The host latch sets pending; a read of group 3 returns it and clears
    // pending.
    send_item(KIND_HOST_WR, 8'hFF, 8'hFF, 10'h3FF);
    send_read(GRP_HOST);
    send_item(KIND_HOST_WR, 8'h00, 8'h00, 10'h000);

    // Bank select keeps only data bits 2:0.
    send_item(KIND_PORT_WR, {GRP_BANK, 6'h00}, 8'hFF, 10'h000);
    send_item(KIND_PORT_WR, {GRP_BANK, 6'h3F}, 8'hF8, 10'h3FF);

    // Writes to groups 2 and 3 must leave everything untouched.
    send_item(KIND_PORT_WR, {GRP_NONE, 6'h00}, 8'hAA, 10'h000);
    send_item(KIND_PORT_WR, {GRP_HOST, 6'h3F}, 8'h55, 10'h3FF);

    // Key-on counts only when one of data bits 6:3 is set.
    write_fm_reg(REG_KEYON, KEYON_MASK);
    send_item(KIND_PORT_WR, {GRP_FM, 6'h01}, 8'h87, 10'h000);

    // Shortest periods for both timers, then load and enable both.
    write_fm_reg(REG_TA_HI, 8'hFF);
    write_fm_reg(REG_TA_LO, 8'h03);
    write_fm_reg(REG_TB, 8'hFF);
    write_fm_reg(REG_TIMER_CTRL, TCTL_LOAD_A | TCTL_LOAD_B | TCTL_EN_A | TCTL_EN_B);

    // A clamped long tick wraps timer A several times; a zero tick changes
    // nothing; four full ticks bring timer B over too.
    send_tick(10'h3FF);
    send_tick(10'h000);
    repeat (4) send_tick(10'd512);
    send_read(GRP_FM);

    // The address latch still points at the control register: stop both
    // timers and clear both flags, then tick the stopped timers.
    send_item(KIND_PORT_WR, {GRP_FM, 6'h01}, TCTL_CLR_A | TCTL_CLR_B, 10'h000);
    send_tick(10'd512);

    while (items_sent < ITEM_TARGET) send_random_scene();

    in_bus.valid <= 1'b0;
    // Waiting on the clock lets the checker's count of outstanding results catch up.
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
design/fmtr_pkg.sv
design/fmtr_if.sv
design/fmtr_ram.sv
design/fm_chip_timer_register_port_top.sv
verif/fmtr_port_checker.sv
verif/tb.sv
